// ===== rtl/wcte_pkg.sv =====
// Types and constants shared by the word clock time encoder.
// No dependencies; compiled first.
package wcte_pkg;

  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int WORDS_W  = 10;
  localparam int HWORD_W  = 4;
  localparam int DOTS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  // Phrase word bit positions
  localparam int W_ESIST   = 0;
  localparam int W_UHR     = 1;
  localparam int W_FUENF   = 2;
  localparam int W_ZEHN    = 3;
  localparam int W_VIERTEL = 4;
  localparam int W_ZWANZIG = 5;
  localparam int W_DREIV   = 6;
  localparam int W_HALB    = 7;
  localparam int W_NACH    = 8;
  localparam int W_VOR     = 9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IT_IS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE   = 2'd2;

  // Region codes
  localparam logic [1:0] REGION_WEST  = 2'd0;
  localparam logic [1:0] REGION_RUHR  = 2'd1;
  localparam logic [1:0] REGION_EAST  = 2'd2;
  localparam logic [1:0] REGION_OTHER = 2'd3;

  // ES IST modes
  localparam logic [1:0] ITIS_OFF    = 2'd0;
  localparam logic [1:0] ITIS_ALWAYS = 2'd1;
  localparam logic [1:0] ITIS_HALF   = 2'd2;

  // Hour word codes for hour one
  localparam logic [HWORD_W-1:0] HW_EIN  = 4'd0;
  localparam logic [HWORD_W-1:0] HW_EINS = 4'd1;

  typedef struct packed {
    logic [1:0] region;
    logic [1:0] it_is_mode;
    logic       fade_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{region: REGION_WEST, it_is_mode: ITIS_ALWAYS,
                                 fade_enable: 1'b0};

endpackage

// ===== rtl/wcte_if.sv =====
// Valid/ready channel interfaces of the word clock time encoder.
// Depends on wcte_pkg for field widths.
interface wcte_in_if import wcte_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  modport source(output valid, hour, minute, input ready);
  modport sink(input valid, hour, minute, output ready);
endinterface

interface wcte_out_if import wcte_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORDS_W-1:0] phrase_words;
  logic [HWORD_W-1:0] hour_word;
  logic [DOTS_W-1:0]  minute_dots;
  logic               light_mode;
  modport source(output valid, phrase_words, hour_word, minute_dots, light_mode,
                 input ready);
  modport sink(input valid, phrase_words, hour_word, minute_dots, light_mode,
               output ready);
endinterface

interface wcte_cfg_if import wcte_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/word_clock_time_encoder_unit.sv =====
// German word clock encoder: time of day in, lit words out.
// Depends on wcte_pkg and the channel interfaces in wcte_if.sv.
//
// One time request is taken every cycle while the sink does not stall the result; its
// result passes through the input register and then the result register,
// with the word decode between them. With the result held by the sink, one
// more request is still taken into the input register. Configuration writes
// are always ready and take effect on requests decoded afterwards.
module word_clock_time_encoder_unit import wcte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  wcte_in_if.sink     in_ch,
  wcte_out_if.source  out_ch,
  wcte_cfg_if.sink    cfg
);

  cfg_t cfg_reg;

  logic                s1_valid;
  logic [HOUR_W-1:0]   s1_hour;
  logic [MINUTE_W-1:0] s1_minute;

  logic               out_valid;
  logic [WORDS_W-1:0] out_words;
  logic [HWORD_W-1:0] out_hword;
  logic [DOTS_W-1:0]  out_dots;
  logic               out_light;

  logic advance;
  logic in_ready;

  logic [9:0]          prod;
  logic [3:0]          quot;
  logic [MINUTE_W-1:0] quot5;
  logic [MINUTE_W-1:0] rem_full;
  logic [3:0]          h12;
  logic [3:0]          h_adv;
  logic                hour_next;
  logic [WORDS_W-1:0]  words_next;
  logic [HWORD_W-1:0]  hword_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg <= CFG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_REGION: cfg_reg.region      <= cfg.data;
        CFG_IT_IS:  cfg_reg.it_is_mode  <= cfg.data;
        CFG_FADE:   cfg_reg.fade_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign advance     = !out_valid || out_ch.ready;
  assign in_ready    = !s1_valid || advance;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_hour   <= in_ch.hour;
      s1_minute <= in_ch.minute;
    end
  end

  // minute / 5 as (minute * 13) >> 6, exact for minute < 64
  always_comb begin
    prod     = 10'(s1_minute) * 10'd13;
    quot     = prod[9:6];
    quot5    = {quot, 2'b00} + 6'(quot);
    rem_full = s1_minute - quot5;
  end

  always_comb begin
    if (s1_hour >= 5'd24) begin
      h12 = 4'(s1_hour - 5'd24);
    end else if (s1_hour >= 5'd12) begin
      h12 = 4'(s1_hour - 5'd12);
    end else begin
      h12 = s1_hour[3:0];
    end
    if (h12 == 4'd0) begin
      h12 = 4'd12;
    end
  end

  always_comb begin
    words_next = '0;
    if (cfg_reg.it_is_mode == ITIS_ALWAYS ||
        (cfg_reg.it_is_mode == ITIS_HALF && (quot == 4'd0 || quot == 4'd6))) begin
      words_next[W_ESIST] = 1'b1;
    end
    case (quot)
      4'd0: words_next[W_UHR] = 1'b1;
      4'd1: begin
        words_next[W_FUENF] = 1'b1;
        words_next[W_NACH]  = 1'b1;
      end
      4'd2: begin
        words_next[W_ZEHN] = 1'b1;
        words_next[W_NACH] = 1'b1;
      end
      4'd3: begin
        words_next[W_VIERTEL] = 1'b1;
        words_next[W_NACH]    = (cfg_reg.region != REGION_EAST);
      end
      4'd4: begin
        if (cfg_reg.region == REGION_RUHR) begin
          words_next[W_ZWANZIG] = 1'b1;
          words_next[W_NACH]    = 1'b1;
        end else begin
          words_next[W_ZEHN] = 1'b1;
          words_next[W_VOR]  = 1'b1;
          words_next[W_HALB] = 1'b1;
        end
      end
      4'd5: begin
        words_next[W_FUENF] = 1'b1;
        words_next[W_VOR]   = 1'b1;
        words_next[W_HALB]  = 1'b1;
      end
      4'd6: words_next[W_HALB] = 1'b1;
      4'd7: begin
        words_next[W_FUENF] = 1'b1;
        words_next[W_NACH]  = 1'b1;
        words_next[W_HALB]  = 1'b1;
      end
      4'd8: begin
        if (cfg_reg.region == REGION_RUHR) begin
          words_next[W_ZWANZIG] = 1'b1;
          words_next[W_VOR]     = 1'b1;
        end else begin
          words_next[W_ZEHN] = 1'b1;
          words_next[W_NACH] = 1'b1;
          words_next[W_HALB] = 1'b1;
        end
      end
      4'd9: begin
        if (cfg_reg.region == REGION_EAST) begin
          words_next[W_DREIV] = 1'b1;
        end else begin
          words_next[W_VIERTEL] = 1'b1;
          words_next[W_VOR]     = 1'b1;
        end
      end
      4'd10: begin
        words_next[W_ZEHN] = 1'b1;
        words_next[W_VOR]  = 1'b1;
      end
      4'd11: begin
        words_next[W_FUENF] = 1'b1;
        words_next[W_VOR]   = 1'b1;
      end
      default: ;  // minute 60 and up lights no minute words
    endcase
  end

  // Next hour is named from a region-dependent minute on
  always_comb begin
    case (cfg_reg.region)
      REGION_WEST: hour_next = (quot >= 4'd4);
      REGION_RUHR: hour_next = (quot >= 4'd5);
      REGION_EAST: hour_next = (quot >= 4'd3);
      default:     hour_next = 1'b0;
    endcase
    if (hour_next) begin
      h_adv = (h12 == 4'd12) ? 4'd1 : h12 + 4'd1;
    end else begin
      h_adv = h12;
    end
    if (h_adv == 4'd1) begin
      hword_next = (quot == 4'd0) ? HW_EIN : HW_EINS;
    end else begin
      hword_next = h_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_words <= words_next;
      out_hword <= hword_next;
      out_dots  <= rem_full[DOTS_W-1:0];
      out_light <= ~cfg_reg.fade_enable;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.phrase_words = out_words;
  assign out_ch.hour_word    = out_hword;
  assign out_ch.minute_dots  = out_dots;
  assign out_ch.light_mode   = out_light;

endmodule

// ===== rtl/wcte_checker.sv =====
// Port-level checks for word_clock_time_encoder_unit, bound to the top level.
// Depends on wcte_pkg and the top level's interface ports.
module wcte_checker import wcte_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [WORDS_W-1:0] phrase_words,
  input logic [HWORD_W-1:0] hour_word,
  input logic [DOTS_W-1:0]  minute_dots,
  input logic               light_mode
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(phrase_words) && $stable(hour_word) &&
      $stable(minute_dots) && $stable(light_mode))
    else $error("result changed while stalled");

  a_dots_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> minute_dots <= 3'd4)
    else $error("minute dots out of range");

  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hour_word <= 4'd12)
    else $error("hour word out of range");

  // UHR never together with NACH or VOR; NACH and VOR never together
  a_words_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(phrase_words[W_NACH] && phrase_words[W_VOR]) &&
      !(phrase_words[W_UHR] && (phrase_words[W_NACH] || phrase_words[W_VOR])))
    else $error("conflicting phrase words");

endmodule

bind word_clock_time_encoder_unit wcte_checker u_wcte_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .phrase_words (out_ch.phrase_words),
  .hour_word    (out_ch.hour_word),
  .minute_dots  (out_ch.minute_dots),
  .light_mode   (out_ch.light_mode)
);

// ===== verif/word_clock_face_checker.sv =====
// Checker for the word clock time encoder: watches the time, result and register channels,
// predicts each clock face and compares it field by field. Depends on wcte_pkg and wcte_if.sv.
module word_clock_face_checker import wcte_pkg::*; (
  input  logic clk,
  input  logic rst,
  wcte_in_if   in_ch,
  wcte_out_if  out_ch,
  wcte_cfg_if  cfg,
  output int   errors,
  output int   pending,
  output int   compared
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORDS_W-1:0] phrase_words;
    logic [HWORD_W-1:0] hour_word;
    logic [DOTS_W-1:0]  minute_dots;
    logic               light_mode;
  } face_t;

  cfg_t  settings;
  face_t expected_faces[$];

  function automatic face_t encode_time(logic [HOUR_W-1:0] hour, logic [MINUTE_W-1:0] minute,
                                        cfg_t c);
    int                 h;
    int                 m;
    logic [WORDS_W-1:0] w;
    face_t              f;
    h = int'(hour) % 12;
    if (h == 0) h = 12;
    m = int'(minute);
    w = '0;
    if (c.it_is_mode == ITIS_ALWAYS ||
        (c.it_is_mode == ITIS_HALF && (m < 5 || (m >= 30 && m < 35))))
      w[W_ESIST] = 1'b1;
    if (m < 5) begin
      w[W_UHR] = 1'b1;
    end else if (m < 10) begin
      w[W_FUENF] = 1'b1; w[W_NACH] = 1'b1;
    end else if (m < 15) begin
      w[W_ZEHN] = 1'b1; w[W_NACH] = 1'b1;
    end else if (m < 20) begin
      w[W_VIERTEL] = 1'b1;
      if (c.region != REGION_EAST) w[W_NACH] = 1'b1;
    end else if (m < 25) begin
      if (c.region == REGION_RUHR) begin
        w[W_ZWANZIG] = 1'b1; w[W_NACH] = 1'b1;
      end else begin
        w[W_ZEHN] = 1'b1; w[W_VOR] = 1'b1; w[W_HALB] = 1'b1;
      end
    end else if (m < 30) begin
      w[W_FUENF] = 1'b1; w[W_VOR] = 1'b1; w[W_HALB] = 1'b1;
    end else if (m < 35) begin
      w[W_HALB] = 1'b1;
    end else if (m < 40) begin
      w[W_FUENF] = 1'b1; w[W_NACH] = 1'b1; w[W_HALB] = 1'b1;
    end else if (m < 45) begin
      if (c.region == REGION_RUHR) begin
        w[W_ZWANZIG] = 1'b1; w[W_VOR] = 1'b1;
      end else begin
        w[W_ZEHN] = 1'b1; w[W_NACH] = 1'b1; w[W_HALB] = 1'b1;
      end
    end else if (m < 50) begin
      if (c.region == REGION_EAST) begin
        w[W_DREIV] = 1'b1;
      end else begin
        w[W_VIERTEL] = 1'b1; w[W_VOR] = 1'b1;
      end
    end else if (m < 55) begin
      w[W_ZEHN] = 1'b1; w[W_VOR] = 1'b1;
    end else if (m < 60) begin
      w[W_FUENF] = 1'b1; w[W_VOR] = 1'b1;
    end
    // past the regional threshold the next hour is named; minutes 60..63 included
    if ((c.region == REGION_RUHR && m >= 25) || (c.region == REGION_WEST && m >= 20) ||
        (c.region == REGION_EAST && m >= 15)) begin
      h++;
      if (h > 12) h = 1;
    end
    f.phrase_words = w;
    if (h == 1) f.hour_word = (m < 5) ? HW_EIN : HW_EINS;
    else f.hour_word = h[HWORD_W-1:0];
    f.minute_dots = 3'(m % 5);
    f.light_mode  = ~c.fade_enable;
    return f;
  endfunction

  task automatic check_field(input string field, input int want, input int got, inout int bad);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      bad++;
    end
  endtask

  always @(posedge clk) begin
    face_t want;
    face_t got;
    int    bad;
    bad = 0;
    if (rst) begin
      settings <= CFG_RESET;
      expected_faces.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.phrase_words, out_ch.hour_word, out_ch.minute_dots, out_ch.light_mode};
        if (expected_faces.size() == 0) begin
          $display("%0t: result with no request waiting, actual %0h", $time, got);
          bad++;
        end else begin
          want = expected_faces.pop_front();
          check_field("phrase_words", want.phrase_words, got.phrase_words, bad);
          check_field("hour_word", want.hour_word, got.hour_word, bad);
          check_field("minute_dots", want.minute_dots, got.minute_dots, bad);
          check_field("light_mode", want.light_mode, got.light_mode, bad);
          compared <= compared + 1;
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_faces.push_back(encode_time(in_ch.hour, in_ch.minute, settings));
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_REGION: settings.region      <= cfg.data;
          CFG_IT_IS:  settings.it_is_mode  <= cfg.data;
          CFG_FADE:   settings.fade_enable <= cfg.data[0];
          default: ;
        endcase
      end
    end
    errors  <= errors + bad;
    pending <= expected_faces.size();
  end

endmodule

// ===== verif/word_clock_time_encoder_unit_tb.sv =====
// Top of the word clock time encoder testbench: clock, reset, time requests, result stalls,
// register writes and the verdict. Depends on wcte_pkg, wcte_if.sv and word_clock_face_checker.
module word_clock_time_encoder_unit_tb import wcte_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 50;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
  localparam logic [1:0]           ITIS_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wcte_in_if  time_req();
  wcte_out_if face_rsp();
  wcte_cfg_if cfg_wr();

  int fail_count;
  int pending_count;
  int compared_count;
  int sent;
  int idle_cycles;
  int hold_requests;
  int hold_served;
  int hold_left;
  int sink_gap;
  bit sink_stalls;

  // edges of every minute band, hour wrap, hour one and out-of-range fields
  int dir_hour[22]   = '{0, 1, 1, 12, 23, 24, 31, 13, 6, 7, 8, 9, 10, 11, 14, 15, 0, 12, 2,
                         3, 4, 5};
  int dir_minute[22] = '{0, 0, 5, 20, 59, 7, 63, 10, 15, 25, 30, 35, 40, 45, 50, 55, 60, 62,
                         4, 34, 19, 44};

  word_clock_time_encoder_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (time_req),
    .out_ch (face_rsp),
    .cfg    (cfg_wr)
  );

  word_clock_face_checker chk (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (time_req),
    .out_ch   (face_rsp),
    .cfg      (cfg_wr),
    .errors   (fail_count),
    .pending  (pending_count),
    .compared (compared_count)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_time(input logic [HOUR_W-1:0] h, input logic [MINUTE_W-1:0] m,
                           input int gap);
    if (gap > 0) begin
      time_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    time_req.valid  <= 1'b1;
    time_req.hour   <= h;
    time_req.minute <= m;
    do @(posedge clk); while (!time_req.ready);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= value;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
  endtask

  task automatic drain_results();
    time_req.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // result side: random stalls plus a long hold-off on request from the stimulus
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served    <= hold_requests;
      hold_left      <= HOLD_CYCLES;
      face_rsp.ready <= 1'b0;
    end else if (hold_left > 0 || sink_gap > 0) begin
      face_rsp.ready <= 1'b0;
      if (hold_left > 0) hold_left <= hold_left - 1;
      else sink_gap <= sink_gap - 1;
    end else begin
      face_rsp.ready <= 1'b1;
      sink_gap       <= sink_stalls ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (time_req.valid && time_req.ready) || (face_rsp.valid && face_rsp.ready) ||
        (cfg_wr.valid && cfg_wr.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [1:0]            region_set;
    logic [1:0]            it_is_set;
    logic [CFG_DATA_W-1:0] fade_set;
    logic [HOUR_W-1:0]     h;
    logic [MINUTE_W-1:0]   m;
    bit                    send_stalls;
    time_req.valid  <= 1'b0;
    time_req.hour   <= '0;
    time_req.minute <= '0;
    cfg_wr.valid    <= 1'b0;
    cfg_wr.index    <= CFG_REGION;
    cfg_wr.data     <= '0;
    sink_stalls     <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed pass under the reset settings
    foreach (dir_hour[i])
      send_time(HOUR_W'(dir_hour[i]), MINUTE_W'(dir_minute[i]), 0);
    drain_results();

    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      case (phase)
        1: begin region_set = REGION_RUHR;  it_is_set = ITIS_HALF;   fade_set = 2'd1; end
        2: begin region_set = REGION_EAST;  it_is_set = ITIS_OFF;    fade_set = 2'd0; end
        3: begin region_set = REGION_OTHER; it_is_set = ITIS_SPARE;  fade_set = 2'd3; end
        4: begin region_set = REGION_WEST;  it_is_set = ITIS_ALWAYS; fade_set = 2'd2; end
        default: begin
          region_set = 2'($urandom_range(0, 3));
          it_is_set  = 2'($urandom_range(0, 3));
          fade_set   = CFG_DATA_W'($urandom_range(0, 3));
        end
      endcase
      write_reg(CFG_REGION, region_set);
      write_reg(CFG_IT_IS, it_is_set);
      write_reg(CFG_FADE, fade_set);
      // the unused index must leave every setting alone
      if (phase == 5) write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 3)));

      send_stalls = (phase != 1);
      sink_stalls <= (phase != 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 10) hold_requests <= hold_requests + 1;
        h = HOUR_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 23)
                                                  : $urandom_range(24, 31));
        m = MINUTE_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 59)
                                                    : $urandom_range(60, 63));
        send_time(h, m, send_stalls ? pick_gap() : 0);
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("tb: %0d time requests over %0d register settings, %0d faces compared",
             sent, NUM_PHASES + 1, compared_count);
    $display("tb: all regions and ES IST modes, hour and minute wrap, one long result hold-off");
    if (fail_count == 0 && pending_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wcte_pkg.sv
rtl/wcte_if.sv
rtl/word_clock_time_encoder_unit.sv
rtl/wcte_checker.sv
verif/word_clock_face_checker.sv
verif/word_clock_time_encoder_unit_tb.sv
